// ----- rtl/core/brb_pkg.sv -----
// Package for the byte ring buffer: sizes, operation codes and beat types.
// Has no dependencies; the top level and the checker import it.
package brb_pkg;

  // Ring storage and field widths.
  localparam int unsigned SLOTS     = 4096;
  localparam int unsigned PTR_W     = $clog2(SLOTS);
  localparam int unsigned LEN_W     = PTR_W + 1;
  localparam int unsigned CAP_W     = 12;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // Register map and reset values.
  localparam logic              CAPACITY_IDX = 1'b0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 12'd4095;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK      = 3'd2;
  localparam logic [OP_W-1:0] OP_ADV_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_ADV_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  // Input beat: one operation.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_in;
    logic [CNT_W-1:0]  amount;
  } brb_req_t;

  // Output beat: read byte and ring status.
  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              done_res;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  free_bytes;
    logic [CNT_W-1:0]  contig_enqueue;
    logic [CNT_W-1:0]  contig_dequeue;
  } brb_rsp_t;

endpackage

// ----- rtl/core/brb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/byte_ring_buffer.sv -----
// Top level of the byte ring buffer: pointer logic, status and APB register.
// Depends on brb_pkg and brb_ram.
//
//   channel   direction   handshake                 payload
//   in        sink        in_valid_i / in_ready_o    brb_req_t  (op, data_in, amount)
//   out       source      out_valid_o / out_ready_i  brb_rsp_t  (byte and status)
//   apb       slave       psel/penable/pwrite        capacity register at address 0
//
// One operation is taken per cycle while input ready is high; one pop or peek
// a cycle uses the single read port; results pass the middle and output stages.
// Reset clears both pointers and sets the capacity to 4095; the store is not cleared.
// A stalled output holds its beat while one more operation is taken into the middle
// stage; input ready drops only when both stages are full and the output is stalled.
module byte_ring_buffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  brb_pkg::brb_req_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output brb_pkg::brb_rsp_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brb_pkg::APB_AW-1:0]        paddr,
  input  logic [brb_pkg::APB_DW-1:0]        pwdata,
  output logic [brb_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import brb_pkg::*;

  // Middle stage: outcome of the operation and the pointers it left.
  typedef struct packed {
    logic             rd;
    logic             done;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } s1_t;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic             s1_valid_q, s1_valid_d;
  s1_t              s1_q, s1_d;
  logic             out_valid_q, out_valid_d;
  brb_rsp_t         out_q, out_d;

  logic             cfg_wr;
  logic             accept;
  logic             s1_adv;
  logic [LEN_W-1:0] len_full;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_m1;
  logic [PTR_W-1:0] amt_sat;
  logic [LEN_W-1:0] used_now;
  logic [LEN_W-1:0] free_now;
  logic [PTR_W-1:0] peek_addr;
  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [LEN_W-1:0] st_used;
  logic [LEN_W-1:0] st_ce;
  logic [LEN_W-1:0] st_cd;

  // Pointer add that wraps by one subtraction of the ring length.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] p, logic [PTR_W-1:0] n,
                                                logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= l) begin
      s = s - l;
    end
    return s[PTR_W-1:0];
  endfunction

  // Bytes held between two pointers.
  function automatic logic [LEN_W-1:0] used_of(logic [PTR_W-1:0] h, logic [PTR_W-1:0] t,
                                               logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] u;
    u = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      u = u + l;
    end
    return u;
  endfunction

  // APB register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CAPACITY_IDX);
  assign prdata = (paddr[2] == CAPACITY_IDX) ? APB_DW'(cap_q) : '0;
  assign cap_d  = cfg_wr ? pwdata[CAP_W-1:0] : cap_q;

  // Handshake of the two stages.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Ring length, limited to the store size, and current fill.
  assign len_full = LEN_W'(cap_q) + LEN_W'(1);
  assign len      = (len_full > LEN_W'(SLOTS)) ? LEN_W'(SLOTS) : len_full;
  assign len_m1   = len - LEN_W'(1);
  assign amt_sat  = (LEN_W'(in_data_i.amount) > len_m1) ? len_m1[PTR_W-1:0]
                                                        : PTR_W'(in_data_i.amount);
  assign used_now = used_of(head_q, tail_q, len);
  assign free_now = len_m1 - used_now;
  assign peek_addr = wrap_add(head_q, amt_sat, len);

  // Operation decode: pointer moves and store access.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    s1_d      = s1_q;
    if (accept) begin
      s1_d.rd   = 1'b0;
      s1_d.done = 1'b0;
      unique case (in_data_i.op)
        OP_PUSH: begin
          if (free_now != '0) begin
            ram_we    = 1'b1;
            tail_d    = wrap_add(tail_q, PTR_W'(1), len);
            s1_d.done = 1'b1;
          end
        end
        OP_POP: begin
          if (used_now != '0) begin
            ram_re    = 1'b1;
            head_d    = wrap_add(head_q, PTR_W'(1), len);
            s1_d.rd   = 1'b1;
            s1_d.done = 1'b1;
          end
        end
        OP_PEEK: begin
          if (LEN_W'(amt_sat) < used_now) begin
            ram_re    = 1'b1;
            ram_raddr = peek_addr;
            s1_d.rd   = 1'b1;
            s1_d.done = 1'b1;
          end
        end
        OP_ADV_REAR: begin
          tail_d = wrap_add(tail_q, amt_sat, len);
        end
        OP_ADV_FRONT: begin
          head_d = wrap_add(head_q, amt_sat, len);
        end
        OP_CLEAR: begin
          head_d = '0;
          tail_d = '0;
        end
        default: begin
        end
      endcase
      s1_d.head = head_d;
      s1_d.tail = tail_d;
    end
    if (cfg_wr) begin
      head_d = '0;
      tail_d = '0;
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  // Byte store.
  brb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SLOTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(in_data_i.data_in),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Status from the pointers the operation left.
  always_comb begin
    st_used = used_of(s1_q.head, s1_q.tail, len);
    if (s1_q.head <= s1_q.tail) begin
      st_ce = len - LEN_W'(s1_q.tail) - ((s1_q.head == '0) ? LEN_W'(1) : LEN_W'(0));
      st_cd = LEN_W'(s1_q.tail) - LEN_W'(s1_q.head);
    end else begin
      st_ce = LEN_W'(s1_q.head) - LEN_W'(s1_q.tail) - LEN_W'(1);
      st_cd = len - LEN_W'(s1_q.head);
    end
  end

  // Output register.
  always_comb begin
    out_d = out_q;
    if (s1_adv) begin
      out_d.data_out       = s1_q.rd ? ram_rdata : '0;
      out_d.done_res       = s1_q.done;
      out_d.used_bytes     = st_used[CNT_W-1:0];
      out_d.free_bytes     = CNT_W'(len_m1 - st_used);
      out_d.contig_enqueue = st_ce[CNT_W-1:0];
      out_d.contig_dequeue = st_cd[CNT_W-1:0];
    end
  end

  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

endmodule

// ----- rtl/core/brb_checker.sv -----
// Port-level checker for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer.
module brb_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  brb_pkg::brb_req_t                 in_data_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  brb_pkg::brb_rsp_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brb_pkg::APB_AW-1:0]        paddr,
  input  logic [brb_pkg::APB_DW-1:0]        pwdata,
  input  logic [brb_pkg::APB_DW-1:0]        prdata,
  input  logic                              pready
);

  import brb_pkg::*;

  logic [CAP_W-1:0] cap_q;

  // Shadow of the capacity register as seen on the APB port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CAPACITY_IDX)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // A stalled output beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Held plus free bytes always add up to the capacity.
  a_fill_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.used_bytes} + {1'b0, out_data_o.free_bytes})
                    == {1'b0, cap_q})
    else $error("used and free bytes do not sum to capacity");

  // Contiguous spans never exceed the totals they are part of.
  a_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.contig_enqueue <= out_data_o.free_bytes) &&
                    (out_data_o.contig_dequeue <= out_data_o.used_bytes))
    else $error("contiguous span larger than total");

  // A beat that returned no byte carries zero data.
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.data_out == '0)
    else $error("data returned without a completed read");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);
